// ===== rtl/bsd_pkg.sv =====
// Shared types and constants of the bilinear saddle detector.
// Holds the sequencer state type and the control and status bundles.
// No dependencies.
`timescale 1ns / 1ps

package bsd_pkg;

  // Fixed widths of the port fields.
  localparam int PIX_W   = 16;
  localparam int LEVEL_W = 24;
  localparam int LW_W    = 11;

  // Reset value of the line width register.
  localparam logic [LW_W-1:0] LW_RESET = LW_W'(1024);

  // One quotient bit is produced in each division step.
  localparam int DIV_CNT_W = $clog2(LEVEL_W);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(LEVEL_W - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL_AD,
    ST_MUL_BC,
    ST_PREP,
    ST_CHECK,
    ST_DIV,
    ST_DONE
  } bsd_state_t;

  // Strobes from the sequencer to the datapath and the top level.
  typedef struct packed {
    logic idle;
    logic mem_rd;
    logic mul_ad;
    logic mul_bc;
    logic prep;
    logic check;
    logic div_step;
    logic load_out;
  } bsd_ctl_t;

  // Decisions the datapath hands back to the sequencer.
  typedef struct packed {
    logic saddle;
    logic skip_div;
  } bsd_sts_t;

endpackage

// ===== rtl/bsd_row_mem.sv =====
// Single line store for the previous image row.
// One write port and one registered read port; depends on nothing else.
`timescale 1ns / 1ps

module bsd_row_mem #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 16
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/bsd_arith.sv =====
// Arithmetic datapath: saddle test, one shared multiplier, magnitudes and a
// restoring divider stepped one quotient bit per cycle.
// Depends on bsd_pkg for the control and status bundles.
`timescale 1ns / 1ps

module bsd_arith #(
  parameter int PIXEL_BITS    = 16,
  parameter int FRACTION_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bsd_pkg::bsd_ctl_t            ctl,
  input  logic [PIXEL_BITS-1:0]        pix_a,
  input  logic [PIXEL_BITS-1:0]        pix_b,
  input  logic [PIXEL_BITS-1:0]        pix_c,
  input  logic [PIXEL_BITS-1:0]        pix_d,
  output bsd_pkg::bsd_sts_t            sts,
  output logic                         saddle,
  output logic [bsd_pkg::LEVEL_W-1:0]  level
);

  import bsd_pkg::*;

  localparam int PW   = 2 * PIXEL_BITS;          // product width
  localparam int RW   = PIXEL_BITS + 1;          // divisor and remainder width
  localparam int SH   = LEVEL_W - FRACTION_BITS; // scale of the overflow test
  localparam int CMPW = (PW > RW + SH) ? PW : RW + SH;
  localparam int XW   = LEVEL_W + RW;            // dividend width that fits
  localparam int NB   = PW + FRACTION_BITS;
  localparam int NW   = (NB > XW) ? NB : XW;

  logic [PIXEL_BITS-1:0] lo_v, hi_v;
  logic                  below, above;
  logic [PIXEL_BITS-1:0] mul_x, mul_y;
  logic [PW-1:0]         prod;
  logic [PW-1:0]         prod_ad_r, prod_bc_r;
  logic [RW-1:0]         sum_ad, sum_bc;
  logic [PW-1:0]         un_r;
  logic [RW-1:0]         ud_r;
  logic                  ovf_c, zero_c;
  logic                  ovf_r, zero_r, saddle_r;
  logic [NW-1:0]         n_full;
  logic [RW-1:0]         rem_r;
  logic [LEVEL_W-1:0]    dvd_r;
  logic [RW:0]           trial;
  logic                  trial_ge;
  logic [RW:0]           trial_sub;

  // Saddle: both off-diagonal corners strictly below, or both strictly above, the diagonal's range.
  always_comb begin
    lo_v  = (pix_a < pix_d) ? pix_a : pix_d;
    hi_v  = (pix_a < pix_d) ? pix_d : pix_a;
    below = (pix_b < lo_v) && (pix_c < lo_v);
    above = (pix_b > hi_v) && (pix_c > hi_v);
  end

  // The single multiplier serves both products on successive cycles.
  assign mul_x = ctl.mul_ad ? pix_a : pix_b;
  assign mul_y = ctl.mul_ad ? pix_d : pix_c;
  assign prod  = PW'(mul_x) * PW'(mul_y);

  assign sum_ad = RW'(pix_a) + RW'(pix_d);
  assign sum_bc = RW'(pix_b) + RW'(pix_c);

  assign zero_c = (ud_r == '0);
  assign ovf_c  = CMPW'(un_r) >= (CMPW'(ud_r) << SH);
  assign n_full = NW'(un_r) << FRACTION_BITS;

  assign trial     = {rem_r, dvd_r[LEVEL_W-1]};
  assign trial_ge  = trial >= {1'b0, ud_r};
  assign trial_sub = trial - {1'b0, ud_r};

  always_ff @(posedge clk) begin
    if (ctl.mul_ad) begin
      prod_ad_r <= prod;
      saddle_r  <= below || above;
    end
    if (ctl.mul_bc) begin
      prod_bc_r <= prod;
    end
    if (ctl.prep) begin
      un_r <= (prod_ad_r >= prod_bc_r) ? prod_ad_r - prod_bc_r : prod_bc_r - prod_ad_r;
      ud_r <= (sum_ad >= sum_bc) ? sum_ad - sum_bc : sum_bc - sum_ad;
    end
    if (ctl.check) begin
      ovf_r <= ovf_c;
      zero_r <= zero_c;
      // With no overflow the upper part is already below the divisor.
      rem_r <= n_full[XW-1:LEVEL_W];
      dvd_r <= n_full[LEVEL_W-1:0];
    end else if (ctl.div_step) begin
      rem_r <= trial_ge ? trial_sub[RW-1:0] : trial[RW-1:0];
      dvd_r <= {dvd_r[LEVEL_W-2:0], trial_ge};
    end
  end

  assign sts.saddle   = below || above;
  assign sts.skip_div = zero_c || ovf_c;
  assign saddle       = saddle_r;
  assign level        = zero_r ? '0 : (ovf_r ? '1 : dvd_r);

  // The partial remainder stays below the divisor throughout the division.
  assert property (@(posedge clk) disable iff (!rst_n)
    ctl.div_step |-> (rem_r < ud_r))
    else $error("division remainder reached the divisor");

  // A division is only started with a nonzero divisor and no overflow.
  assert property (@(posedge clk) disable iff (!rst_n)
    ctl.check && !sts.skip_div |=> !zero_r && !ovf_r)
    else $error("division started on a saturated or zero case");

  // The shared multiplier is never asked for both products at once.
  assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.mul_ad && ctl.mul_bc))
    else $error("multiplier claimed twice in one cycle");

endmodule

// ===== rtl/bsd_ctrl.sv =====
// Sequencer of the saddle detector: steps one item through read, multiply,
// magnitude, check and the bit-serial division. Depends on bsd_pkg.
`timescale 1ns / 1ps

module bsd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              cell_valid,
  input  logic              out_free,
  input  bsd_pkg::bsd_sts_t sts,
  output bsd_pkg::bsd_ctl_t ctl
);

  import bsd_pkg::*;

  bsd_state_t             state_r, state_nxt;
  logic [DIV_CNT_W-1:0]   div_cnt_r, div_cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      div_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      div_cnt_r <= div_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    div_cnt_nxt = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ:   state_nxt = ST_MUL_AD;
      ST_MUL_AD: begin
        state_nxt = (cell_valid && sts.saddle) ? ST_MUL_BC : ST_DONE;
      end
      ST_MUL_BC: state_nxt = ST_PREP;
      ST_PREP:   state_nxt = ST_CHECK;
      ST_CHECK: begin
        state_nxt = sts.skip_div ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        if (div_cnt_r == DIV_LAST) begin
          state_nxt = ST_DONE;
        end else begin
          div_cnt_nxt = div_cnt_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    case (state_r)
      ST_IDLE:   ctl.idle     = 1'b1;
      ST_READ:   ctl.mem_rd   = 1'b1;
      ST_MUL_AD: ctl.mul_ad   = 1'b1;
      ST_MUL_BC: ctl.mul_bc   = 1'b1;
      ST_PREP:   ctl.prep     = 1'b1;
      ST_CHECK:  ctl.check    = 1'b1;
      ST_DIV:    ctl.div_step = 1'b1;
      ST_DONE:   ctl.load_out = out_free;
      default:   ctl = '0;
    endcase
  end

  // The step counter only runs during the division.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_DIV) |-> (div_cnt_r == '0))
    else $error("division counter running outside the division");

  // Exactly one result is loaded per started item: the load ends the item.
  assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load_out |=> (state_r == ST_IDLE))
    else $error("result loaded without returning to idle");

  // The sequencer only leaves idle when a pixel is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_IDLE) && !start) |=> (state_r == ST_IDLE))
    else $error("sequencer left idle without a pixel");

endmodule

// ===== rtl/bilinear_saddle_detector.sv =====
// Top level of the bilinear saddle detector: line position tracking, the
// row store, the sequencer, the arithmetic datapath and the result register.
// Depends on bsd_pkg, bsd_row_mem, bsd_arith and bsd_ctrl.
`timescale 1ns / 1ps

//  Channel  | Ports                                        | Direction
//  ---------+----------------------------------------------+----------
//  config   | cfg_wr_en, cfg_wr_data                       | in
//  pixels   | in_valid, in_stall, in_pixel, in_frame_start | in
//  results  | out_valid, out_stall, out_cell_valid,        | out
//           | out_is_saddle, out_saddle_level              |
//
//  One pixel is in flight at a time. A cell that holds a saddle is held longest,
//  by the 24 steps of the shared restoring divider; a saturated level and any
//  other pixel skip the division.
//  Reset (rst_n low at a clock edge) clears the position, the neighbour pixels
//  and the line width, which returns to 1024; the row store is not cleared.
//  A stalled result waits in the output register; the next pixel is taken
//  meanwhile and only its own result waits for the register to drain.

module bilinear_saddle_detector #(
  parameter int MAX_WIDTH     = 1024,
  parameter int PIXEL_BITS    = 16,
  parameter int FRACTION_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [bsd_pkg::LW_W-1:0]     cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [bsd_pkg::PIX_W-1:0]    in_pixel,
  input  logic                         in_frame_start,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_cell_valid,
  output logic                         out_is_saddle,
  output logic [bsd_pkg::LEVEL_W-1:0]  out_saddle_level
);

  import bsd_pkg::*;

  localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CWB = $clog2(MAX_WIDTH + 1);
  // Width comparisons are made wide enough for both the register and the count.
  localparam int EWB = (LW_W > CWB) ? LW_W : CWB;

  bsd_ctl_t ctl;
  bsd_sts_t sts;

  logic                  in_accept;
  logic                  out_free;
  logic [LW_W-1:0]       line_width_r;
  logic [AW-1:0]         col_cnt_r, col_cnt_nxt;
  logic                  past_row_r, past_row_nxt;
  logic [PIXEL_BITS-1:0] left_r, upleft_r;

  // Working copy of the pixel being processed.
  logic [AW-1:0]         col_r;
  logic                  valid_r;
  logic [PIXEL_BITS-1:0] a_r, c_r, d_r;
  logic [PIXEL_BITS-1:0] above_pix;

  logic [EWB-1:0]        lw_ext, eff_w, cnt_ext, col_inc;
  logic [AW-1:0]         cnt_start, col_now;
  logic                  past_start, past_now, cell_now;

  logic                  saddle;
  logic [LEVEL_W-1:0]    level;

  logic                  out_valid_r, out_cell_valid_r, out_is_saddle_r;
  logic [LEVEL_W-1:0]    out_saddle_level_r;

  assign in_stall  = !ctl.idle;
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // The line width register holds the value as written; it is clamped into
  // the range the row store supports where it is used.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= LW_RESET;
    end else if (cfg_wr_en) begin
      line_width_r <= cfg_wr_data;
    end
  end

  // Position in the raster. A frame start restarts at column 0 of the first
  // row; a counter left beyond a narrowed width wraps before it is used.
  always_comb begin
    lw_ext = EWB'(line_width_r);
    if (lw_ext < EWB'(2)) begin
      eff_w = EWB'(2);
    end else if (lw_ext > EWB'(MAX_WIDTH)) begin
      eff_w = EWB'(MAX_WIDTH);
    end else begin
      eff_w = lw_ext;
    end

    cnt_start  = in_frame_start ? '0 : col_cnt_r;
    past_start = in_frame_start ? 1'b0 : past_row_r;
    cnt_ext    = EWB'(cnt_start);
    if (cnt_ext >= eff_w) begin
      col_now  = '0;
      past_now = 1'b1;
    end else begin
      col_now  = cnt_start;
      past_now = past_start;
    end
    cell_now = past_now && (col_now != '0);

    col_inc = EWB'(col_now) + EWB'(1);
    if (col_inc >= eff_w) begin
      col_cnt_nxt  = '0;
      past_row_nxt = 1'b1;
    end else begin
      col_cnt_nxt  = AW'(col_inc);
      past_row_nxt = past_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r  <= '0;
      past_row_r <= 1'b0;
      left_r     <= '0;
      upleft_r   <= '0;
    end else begin
      if (in_accept) begin
        col_cnt_r  <= col_cnt_nxt;
        past_row_r <= past_row_nxt;
        left_r     <= in_pixel[PIXEL_BITS-1:0];
      end
      // The pixel above becomes the next cell's top-left corner.
      if (ctl.mul_ad) begin
        upleft_r <= above_pix;
      end
    end
  end

  // Corners a and c are the neighbours held before this pixel's transfer.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      col_r   <= col_now;
      valid_r <= cell_now;
      a_r     <= upleft_r;
      c_r     <= left_r;
      d_r     <= in_pixel[PIXEL_BITS-1:0];
    end
  end

  // The column is read first and overwritten with the new pixel in the next cycle.
  bsd_row_mem #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (PIXEL_BITS)
  ) u_row_mem (
    .clk     (clk),
    .rd_en   (ctl.mem_rd),
    .rd_addr (col_r),
    .rd_data (above_pix),
    .wr_en   (ctl.mul_ad),
    .wr_addr (col_r),
    .wr_data (d_r)
  );

  bsd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_accept),
    .cell_valid (valid_r),
    .out_free   (out_free),
    .sts        (sts),
    .ctl        (ctl)
  );

  bsd_arith #(
    .PIXEL_BITS    (PIXEL_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_arith (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .pix_a  (a_r),
    .pix_b  (above_pix),
    .pix_c  (c_r),
    .pix_d  (d_r),
    .sts    (sts),
    .saddle (saddle),
    .level  (level)
  );

  // Result register. It drains on a transfer and refills when the sequencer
  // finishes a pixel, which it only does while the register is free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_cell_valid_r   <= valid_r;
      out_is_saddle_r    <= valid_r && saddle;
      out_saddle_level_r <= (valid_r && saddle) ? level : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_cell_valid   = out_cell_valid_r;
  assign out_is_saddle    = out_is_saddle_r;
  assign out_saddle_level = out_saddle_level_r;

  // After a pixel transfer the input is held off while it is worked on.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> in_stall)
    else $error("second pixel taken while one is in flight");

  // A saddle is only reported for a complete cell.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_is_saddle_r || out_cell_valid_r))
    else $error("saddle flagged on an incomplete cell");

  // A cell without a saddle reports a zero level.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_is_saddle_r) |-> (out_saddle_level_r == '0))
    else $error("nonzero level without a saddle");

  // A new result is never loaded over one that is still stalled.
  assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load_out |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten while stalled");

endmodule
